### sv/assert_macros.svh
// assertion macros used by the checker file ffd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: property failed");

`endif

### sv/ffd_pkg.sv
// types and constants of the first-flush diverter controller
package ffd_pkg;

   // diverter phase, one-hot
   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_CONFIRM = 4'b0010,
      PH_DIVERT  = 4'b0100,
      PH_COLLECT = 4'b1000
   } phase_type;

   // mode codes as seen on the result beat
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_CONFIRM = 2'd1;
   localparam logic [1:0] MODE_DIVERT  = 2'd2;
   localparam logic [1:0] MODE_COLLECT = 2'd3;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLUSH_TIME     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_GATE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REENTRY_WINDOW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_INTERVAL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_TIMEOUT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COLLECT_WINDOW = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_MODE       = 3'd7;

   // volume is kept as mL times this scale (mL/min times ms)
   localparam logic [15:0] VOL_SCALE = 16'd60000;
   localparam int unsigned GATE_W = 40;
   localparam int unsigned VOL_W  = 56;
   localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

   // register defaults
   localparam logic [31:0]       RST_FLUSH_TIME     = 32'd120000;
   localparam logic [GATE_W-1:0] RST_GATE_SCALED    = 40'd3000000000;
   localparam logic [31:0]       RST_REENTRY_WINDOW = 32'd1800000;
   localparam logic [31:0]       RST_PULSE          = 32'd8000;
   localparam logic [31:0]       RST_CHECK_INTERVAL = 32'd60000;
   localparam logic [31:0]       RST_FLOW_TIMEOUT   = 32'd10000;
   localparam logic [31:0]       RST_COLLECT_WINDOW = 32'd300000;

   typedef struct packed {
      logic [31:0]       flush_time;
      logic [GATE_W-1:0] gate_scaled;
      logic [31:0]       reentry_window;
      logic [31:0]       pulse;
      logic [31:0]       check_interval;
      logic [31:0]       flow_timeout;
      logic [31:0]       collect_window;
      logic              cal_mode;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] now_ms;
      logic        flow_active;
      logic [15:0] flow_rate;
   } item_type;

   typedef struct packed {
      logic [VOL_W-1:0] diverted_amount;
      logic             flushed;
      logic             collect_open;
      logic             drain_open;
      logic [1:0]       mode;
   } result_type;

endpackage

### sv/ffd_core.sv
// diverter state registers and the combinational update for one tick or reset command (state held in cal mode)
module ffd_core
   import ffd_pkg::*;
#(
   parameter logic [31:0] CONFIRM_MS = 32'd5000,
   parameter int unsigned TIME_BITS  = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int unsigned TW = TIME_BITS;
   localparam int unsigned NB = (TIME_BITS < 32) ? TIME_BITS : 32;
   localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam int unsigned PW = TIME_BITS + 16;
   localparam int unsigned XW = (PW > VOL_W + 1) ? PW : VOL_W + 1;
   localparam logic [TW-1:0] TMAX = {TW{1'b1}};

   phase_type        phase_ff, phase_in;
   logic             pulsing_ff, pulsing_in;
   logic [TW-1:0]    check_start_ff, check_start_in;
   logic [TW-1:0]    confirm_start_ff, confirm_start_in;
   logic [TW-1:0]    last_flow_ff, last_flow_in;
   logic [TW-1:0]    collect_start_ff, collect_start_in;
   logic [TW-1:0]    flow_sum_ff, flow_sum_in;
   logic [VOL_W-1:0] volume_ff, volume_in;
   logic [TW-1:0]    collect_end_ff, collect_end_in;
   logic             done_ff, done_in;
   logic             skip_ff, skip_in;

   logic [TW-1:0]    now_t;
   logic [TW-1:0]    e_check, e_confirm, e_last, e_cstart, e_cend;
   logic [TW:0]      flow_add;
   logic [TW-1:0]    flow_sat;
   logic [XW-1:0]    prod_x;
   logic [VOL_W-1:0] prod_sat;
   logic [VOL_W:0]   vol_add;
   logic [VOL_W-1:0] vol_sat;
   logic             done_kept;

   function automatic logic time_ge(logic [TW-1:0] e, logic [31:0] c);
      return CW'(e) >= CW'(c);
   endfunction

   function automatic logic [1:0] mode_code(phase_type ph);
      logic [1:0] code;
      unique case (ph)
         PH_IDLE:    code = MODE_IDLE;
         PH_CONFIRM: code = MODE_CONFIRM;
         PH_DIVERT:  code = MODE_DIVERT;
         PH_COLLECT: code = MODE_COLLECT;
         default:    code = MODE_IDLE;
      endcase
      return code;
   endfunction

   assign now_t     = TW'(item.now_ms[NB-1:0]);
   assign e_check   = now_t - check_start_ff;
   assign e_confirm = now_t - confirm_start_ff;
   assign e_last    = now_t - last_flow_ff;
   assign e_cstart  = now_t - collect_start_ff;
   assign e_cend    = now_t - collect_end_ff;

   // saturating accumulators for the diverting phase
   assign flow_add = {1'b0, flow_sum_ff} + {1'b0, e_last};
   assign flow_sat = flow_add[TW] ? TMAX : flow_add[TW-1:0];
   assign prod_x   = XW'(item.flow_rate) * XW'(e_last);
   assign prod_sat = (prod_x > XW'(VOL_MAX)) ? VOL_MAX : prod_x[VOL_W-1:0];
   assign vol_add  = {1'b0, volume_ff} + {1'b0, prod_sat};
   assign vol_sat  = vol_add[VOL_W] ? VOL_MAX : vol_add[VOL_W-1:0];

   // session flag survives only inside the re-entry window
   assign done_kept = done_ff && !time_ge(e_cend, cfg.reentry_window);

   always_comb begin
      phase_in         = phase_ff;
      pulsing_in       = pulsing_ff;
      check_start_in   = check_start_ff;
      confirm_start_in = confirm_start_ff;
      last_flow_in     = last_flow_ff;
      collect_start_in = collect_start_ff;
      flow_sum_in      = flow_sum_ff;
      volume_in        = volume_ff;
      collect_end_in   = collect_end_ff;
      done_in          = done_ff;
      skip_in          = skip_ff;
      if (!cfg.cal_mode) begin
         if (item.kind) begin
            volume_in      = '0;
            done_in        = 1'b0;
            skip_in        = 1'b0;
            collect_end_in = '0;
            phase_in       = PH_IDLE;
            pulsing_in     = 1'b1;
            check_start_in = now_t;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  done_in = done_kept;
                  if (pulsing_ff) begin
                     if (item.flow_active) begin
                        skip_in = done_kept;
                        if (!done_kept) begin
                           volume_in = '0;
                        end
                        phase_in         = PH_CONFIRM;
                        confirm_start_in = now_t;
                        last_flow_in     = now_t;
                        pulsing_in       = 1'b0;
                     end else if (time_ge(e_check, cfg.pulse)) begin
                        pulsing_in     = 1'b0;
                        check_start_in = now_t;
                     end
                  end else if (time_ge(e_check, cfg.check_interval)) begin
                     pulsing_in     = 1'b1;
                     check_start_in = now_t;
                  end
               end
               PH_CONFIRM: begin
                  if (item.flow_active) begin
                     last_flow_in = now_t;
                     if (time_ge(e_confirm, CONFIRM_MS)) begin
                        if (skip_ff) begin
                           skip_in          = 1'b0;
                           phase_in         = PH_COLLECT;
                           collect_start_in = now_t;
                        end else begin
                           phase_in    = PH_DIVERT;
                           flow_sum_in = e_confirm;
                        end
                     end
                  end else begin
                     skip_in        = 1'b0;
                     phase_in       = PH_IDLE;
                     pulsing_in     = 1'b0;
                     check_start_in = now_t;
                  end
               end
               PH_DIVERT: begin
                  if (item.flow_active) begin
                     flow_sum_in  = flow_sat;
                     volume_in    = vol_sat;
                     last_flow_in = now_t;
                     if (time_ge(flow_sat, cfg.flush_time) ||
                         vol_sat >= VOL_W'(cfg.gate_scaled)) begin
                        phase_in         = PH_COLLECT;
                        collect_start_in = now_t;
                     end
                  end else if (CW'(e_last) > CW'(cfg.flow_timeout)) begin
                     phase_in       = PH_IDLE;
                     pulsing_in     = 1'b0;
                     check_start_in = now_t;
                  end
               end
               PH_COLLECT: begin
                  if (item.flow_active) begin
                     last_flow_in = now_t;
                  end else if (time_ge(e_cstart, cfg.collect_window) &&
                               CW'(e_last) > CW'(cfg.flow_timeout)) begin
                     collect_end_in = now_t;
                     done_in        = 1'b1;
                     phase_in       = PH_IDLE;
                     pulsing_in     = 1'b0;
                     check_start_in = now_t;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         pulsing_ff       <= 1'b1;
         check_start_ff   <= '0;
         confirm_start_ff <= '0;
         last_flow_ff     <= '0;
         collect_start_ff <= '0;
         flow_sum_ff      <= '0;
         volume_ff        <= '0;
         collect_end_ff   <= '0;
         done_ff          <= 1'b0;
         skip_ff          <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         pulsing_ff       <= pulsing_in;
         check_start_ff   <= check_start_in;
         confirm_start_ff <= confirm_start_in;
         last_flow_ff     <= last_flow_in;
         collect_start_ff <= collect_start_in;
         flow_sum_ff      <= flow_sum_in;
         volume_ff        <= volume_in;
         collect_end_ff   <= collect_end_in;
         done_ff          <= done_in;
         skip_ff          <= skip_in;
      end
   end

   // result reflects the state after this beat
   always_comb begin
      result.mode            = mode_code(phase_in);
      result.drain_open      = (phase_in == PH_IDLE) ? pulsing_in : (phase_in != PH_COLLECT);
      result.collect_open    = (phase_in == PH_COLLECT);
      result.flushed         = done_in;
      result.diverted_amount = volume_in;
   end

endmodule

### sv/first_flush_diverter_fsm_top.sv
// first-flush diverter controller: input register, register file, core and result register
// path: an accepted beat is held in the input register, and its result beat in the result register
// throughput: one beat per cycle while the result beat is not stalled, bound by the state update in ffd_core
// (elapsed-time subtract, 16 x TIME_BITS multiply, saturating add and gate compare)
// reset: synchronous, active high; empties both registers, loads register defaults
// and puts the machine in idle with the rain-check pulse open
module first_flush_diverter_fsm_top
   import ffd_pkg::*;
#(
   parameter logic [31:0] CONFIRM_MS = 32'd5000,
   parameter int unsigned TIME_BITS  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [55:0]          req_tdata,  // now_ms[31:0], flow_active[32], flow_rate[48:33], zero
   input  logic                 req_tuser,  // kind[0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,  // mode[1:0], drain_open[2], collect_open[3],
                                            // flushed[4], diverted_amount[60:5], zero
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff;
   result_type out_result_ff;
   result_type result;
   cfg_type    cfg_ff;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_result_ff};
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.kind        <= req_tuser;
         in_item_ff.now_ms      <= req_tdata[31:0];
         in_item_ff.flow_active <= req_tdata[32];
         in_item_ff.flow_rate   <= req_tdata[48:33];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result;
      end
   end

   // gate kept pre-scaled so the volume compare needs no multiplier
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flush_time     <= RST_FLUSH_TIME;
         cfg_ff.gate_scaled    <= RST_GATE_SCALED;
         cfg_ff.reentry_window <= RST_REENTRY_WINDOW;
         cfg_ff.pulse          <= RST_PULSE;
         cfg_ff.check_interval <= RST_CHECK_INTERVAL;
         cfg_ff.flow_timeout   <= RST_FLOW_TIMEOUT;
         cfg_ff.collect_window <= RST_COLLECT_WINDOW;
         cfg_ff.cal_mode       <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FLUSH_TIME:     cfg_ff.flush_time     <= csr_data;
            CSR_VOLUME_GATE:    cfg_ff.gate_scaled    <=
                                   GATE_W'(csr_data[23:0]) * GATE_W'(VOL_SCALE);
            CSR_REENTRY_WINDOW: cfg_ff.reentry_window <= csr_data;
            CSR_PULSE:          cfg_ff.pulse          <= csr_data;
            CSR_CHECK_INTERVAL: cfg_ff.check_interval <= csr_data;
            CSR_FLOW_TIMEOUT:   cfg_ff.flow_timeout   <= csr_data;
            CSR_COLLECT_WINDOW: cfg_ff.collect_window <= csr_data;
            CSR_CAL_MODE:       cfg_ff.cal_mode       <= csr_data[0];
            default:            cfg_ff.cal_mode       <= cfg_ff.cal_mode;
         endcase
      end
   end

   ffd_core #(
      .CONFIRM_MS (CONFIRM_MS),
      .TIME_BITS  (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

endmodule

### sv/ffd_checker.sv
// port-level checks of the diverter controller, bound to the top level
`include "assert_macros.svh"

module ffd_checker
   import ffd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // valves never both open, and the collection valve follows the collecting mode
   `ASSERT_CLK(a_valves_exclusive, clock, reset, rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[3]))
   `ASSERT_CLK(a_collect_mode, clock, reset, rsp_tvalid |-> (rsp_tdata[3] == (rsp_tdata[1:0] == MODE_COLLECT)))
   // drain stays open while confirming or diverting
   `ASSERT_CLK(a_drain_active, clock, reset, (rsp_tvalid && (rsp_tdata[1:0] == MODE_CONFIRM || rsp_tdata[1:0] == MODE_DIVERT)) |-> rsp_tdata[2])
   // a stalled result beat holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
   // both registers empty right after reset
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_tvalid && req_tready))

endmodule

bind first_flush_diverter_fsm_top ffd_checker u_checker (.*);
